@@ src/swtq_pkg.sv @@
// Shared types and constants of the sleep and wakeup timer queue.
`timescale 1ns / 1ps

package swtq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam logic FUNC_SLEEP = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_FULL     = 2'd1;
    localparam logic [1:0] KIND_WOKEN    = 2'd2;

    typedef struct packed {
        logic               func;
        logic [15:0]        sleeper_id;
        logic signed [31:0] delay_ticks;
        logic [5:0]         sleeper_priority;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] woken_id;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [63:0] wake;
        logic [15:0] id;
        logic [5:0]  prio;
    } t_entry;

    typedef struct packed {
        logic lt;
        logic eq;
        logic b_prio_below;
    } t_cmp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_WR,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_TICK_END
    } t_state;

endpackage

@@ src/swtq_mem.sv @@
// Queue entry memory with one write port and one registered read port.
`timescale 1ns / 1ps

module swtq_mem
    import swtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW          = $clog2(QUEUE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/swtq_cmp.sv @@
// Shared comparator for wake times and priorities.
`timescale 1ns / 1ps

module swtq_cmp
    import swtq_pkg::*;
(
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [5:0]  i_prio_a,
    input  logic [5:0]  i_prio_b,
    output t_cmp        o_res
);

    always_comb begin
        o_res.lt           = $signed(i_a) < $signed(i_b);
        o_res.eq           = (i_a == i_b);
        o_res.b_prio_below = (i_prio_b < i_prio_a);
    end

endmodule

@@ src/sleep_wakeup_timer_queue_top.sv @@
// Top level of the sleep and wakeup timer queue with its sequencer.
//
// A sleep request keeps busy high while the new entry is compared with e
// queued entries: those that move up one slot, plus the first one that
// stays in place if there is one. The queue is not full when a request is
// taken, so e is at most QUEUE_DEPTH - 1. A tick keeps busy high while d
// entries are examined: the due ones, plus the first one that is not due
// if there is one, so d is at most QUEUE_DEPTH. Every such entry is read
// and then compared, since the single entry memory has a registered read
// port and the one comparator serves every step; a request ends with
// ST_INS_WR and a tick with ST_TICK_END. A request to a full queue and a tick
// on an empty queue finish in the accepting cycle and leave busy low. Each
// result word is shown for exactly one cycle with o_valid high and the
// receiver cannot hold it off. The woken sleepers of a tick come one word
// per due entry. The final one, marked by last, comes from ST_TICK_END,
// which follows the compare that sent the word before it when every queued
// entry was due, and otherwise one more read and compare of an entry.
`timescale 1ns / 1ps

module sleep_wakeup_timer_queue_top
    import swtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_cmd,
    output logic      busy,
    output logic      o_valid,
    output t_out_word o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;

    t_state        r_state, n_state;
    logic [63:0]   r_tick, n_tick;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_j, n_j;
    t_entry        r_new, n_new;
    logic          r_pend_valid, n_pend_valid;
    logic [15:0]   r_pend_id, n_pend_id;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;

    logic          accept;
    logic [CW-1:0] j_m1;
    logic          full;
    logic          goes_ahead;
    logic          due;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic [63:0]   cmp_a;
    t_cmp          cmp_res;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = {1'b0, head} + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    swtq_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .AW         (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    swtq_cmp u_cmp (
        .i_a     (cmp_a),
        .i_b     (mem_rdata.wake),
        .i_prio_a(r_new.prio),
        .i_prio_b(mem_rdata.prio),
        .o_res   (cmp_res)
    );

    assign accept     = start && !busy;
    assign j_m1       = r_j - CW'(1);
    assign full       = (r_count == CW'(QUEUE_DEPTH));
    assign cmp_a      = (r_state == ST_TICK_CMP) ? r_tick : r_new.wake;
    assign goes_ahead = cmp_res.lt || (cmp_res.eq && cmp_res.b_prio_below);
    assign due        = !cmp_res.lt;

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd.func == FUNC_SLEEP) begin
                        if (full) begin
                            n_state = ST_IDLE;
                        end else if (r_count == '0) begin
                            n_state = ST_INS_WR;
                        end else begin
                            n_state = ST_INS_RD;
                        end
                    end else if (r_count != '0) begin
                        n_state = ST_TICK_RD;
                    end
                end
            end
            ST_INS_RD: begin
                n_state = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                if (goes_ahead && j_m1 != '0) begin
                    n_state = ST_INS_RD;
                end else begin
                    n_state = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                n_state = ST_IDLE;
            end
            ST_TICK_RD: begin
                n_state = ST_TICK_CMP;
            end
            ST_TICK_CMP: begin
                if (due && (r_j + CW'(1)) != r_count) begin
                    n_state = ST_TICK_RD;
                end else begin
                    n_state = ST_TICK_END;
                end
            end
            ST_TICK_END: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_tick       = r_tick;
        n_head       = r_head;
        n_count      = r_count;
        n_j          = r_j;
        n_new        = r_new;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_waddr    = f_phys(r_head, r_j);
        mem_wdata    = r_new;
        mem_raddr    = f_phys(r_head, r_j);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_new.wake = r_tick + {{32{i_cmd.delay_ticks[31]}}, i_cmd.delay_ticks};
                    n_new.id   = i_cmd.sleeper_id;
                    n_new.prio = i_cmd.sleeper_priority;
                    if (i_cmd.func == FUNC_SLEEP) begin
                        n_j = r_count;
                        if (full) begin
                            n_out_valid = 1'b1;
                            n_out       = '{kind: KIND_FULL, woken_id: i_cmd.sleeper_id,
                                            last: 1'b1};
                        end
                    end else begin
                        n_tick       = r_tick + 64'd1;
                        n_j          = '0;
                        n_pend_valid = 1'b0;
                    end
                end
            end
            ST_INS_RD: begin
                mem_raddr = f_phys(r_head, j_m1);
            end
            ST_INS_CMP: begin
                if (goes_ahead) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    n_j       = j_m1;
                end
            end
            ST_INS_WR: begin
                mem_we      = 1'b1;
                n_count     = r_count + CW'(1);
                n_out_valid = 1'b1;
                n_out       = '{kind: KIND_ACCEPTED, woken_id: r_new.id, last: 1'b1};
            end
            ST_TICK_RD: begin
                mem_raddr = f_phys(r_head, r_j);
            end
            ST_TICK_CMP: begin
                if (due) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = '{kind: KIND_WOKEN, woken_id: r_pend_id, last: 1'b0};
                    end
                    n_pend_valid = 1'b1;
                    n_pend_id    = mem_rdata.id;
                    n_j          = r_j + CW'(1);
                end
            end
            ST_TICK_END: begin
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_WOKEN, woken_id: r_pend_id, last: 1'b1};
                end
                n_head       = f_phys(r_head, r_j);
                n_count      = r_count - r_j;
                n_pend_valid = 1'b0;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tick       <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tick       <= n_tick;
            r_head       <= n_head;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_new     <= n_new;
        r_pend_id <= n_pend_id;
        r_out     <= n_out;
    end

    // The queue never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // An accepted tick advances the counter by exactly one.
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd.func == FUNC_TICK |=> r_tick == $past(r_tick) + 64'd1)
        else $error("tick counter did not advance by one");

    // Only woken words may be followed by more words of the same command.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last |-> r_out.kind == KIND_WOKEN)
        else $error("non-final word with a kind other than woken");

    // Finishing an insertion adds exactly one entry and acknowledges it.
    a_insert_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_INS_WR |=> r_count == $past(r_count) + CW'(1)
            && r_out_valid && r_out.kind == KIND_ACCEPTED)
        else $error("insertion did not complete correctly");

endmodule
